### hdl/atmnb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atmnb_pkg
// Shared widths, constants and types for the tone timer to MIDI note and
// pitch bend converter.
// ----------------------------------------------------------------------------
package atmnb_pkg;

  localparam int TIMER_W = 11;
  localparam int NOTE_W  = 8;
  localparam int BEND_W  = 14;

  localparam int CLOCK_HZ       = 1789773;
  localparam int A4_HZ          = 440;
  localparam int A4_NOTE        = 69;
  localparam int BEND_CENTRE    = 8192;
  localparam int BEND_PER_SEMI  = 4096;
  localparam int SEMIS_PER_OCT  = 12;
  localparam int PULSE_DIV_LOG2 = 4;
  localparam int TRI_DIV_LOG2   = 5;
  localparam int MANT_BITS      = 30;
  localparam int LOG_FRAC_BITS  = 16;

  localparam int DEN_W     = 20;
  localparam int QUO_W     = 38;
  localparam int NUM_W     = $clog2(CLOCK_HZ) + MANT_BITS - PULSE_DIV_LOG2;
  localparam int MANT_W    = MANT_BITS + 1;
  localparam int LZC_W     = $clog2(QUO_W);
  localparam int EXP_W     = 7;
  localparam int NORM_TOP  = QUO_W - 1 - MANT_BITS;
  localparam int PITCH_W   = 22;
  localparam int FP_W      = 16;
  localparam int SEMI_Q    = SEMIS_PER_OCT * BEND_PER_SEMI;
  localparam int NOTE_BASE = A4_NOTE * BEND_PER_SEMI;
  localparam int SEMI_BITS = $clog2(BEND_PER_SEMI);
  localparam int HALF_SEMI = BEND_PER_SEMI / 2;

  typedef logic [QUO_W-1:0]         quo_t;
  typedef logic [MANT_W-1:0]        mant_t;
  typedef logic signed [EXP_W-1:0]  exp_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [BEND_W-1:0] bend;
  } res_t;

endpackage
`default_nettype wire

### hdl/atmnb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atmnb_if
// Valid/ready channels for timer input and note/bend results.
// ----------------------------------------------------------------------------
interface atmnb_in_if;
  logic                         valid;
  logic                         ready;
  logic [atmnb_pkg::TIMER_W-1:0] timer;
  logic                         op;

  modport source (output valid, output timer, output op, input ready);
  modport sink   (input valid, input timer, input op, output ready);
endinterface

interface atmnb_out_if;
  logic                        valid;
  logic                        ready;
  logic [atmnb_pkg::NOTE_W-1:0] note;
  logic [atmnb_pkg::BEND_W-1:0] bend;

  modport source (output valid, output note, output bend, input ready);
  modport sink   (input valid, input note, input bend, output ready);
endinterface
`default_nettype wire

### hdl/atmnb_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atmnb_div
// Forms the frequency ratio to 440 Hz in Q30 with a restoring divider that
// resolves one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module atmnb_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [atmnb_pkg::TIMER_W-1:0] timer,
  input  logic                          op,
  output logic                          out_valid,
  output atmnb_pkg::quo_t               quo
);

  localparam int QW = atmnb_pkg::QUO_W;
  localparam int DW = atmnb_pkg::DEN_W;
  localparam int NW = atmnb_pkg::NUM_W;

  logic          v_r   [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [DW-1:0] rem_r [QW+1];
  logic [QW-1:0] nq_r  [QW+1];

  logic [NW-1:0] num_nxt;
  logic [DW-1:0] den_nxt;

  // The channel divider is a power of two, so it folds into the dividend.
  always_comb begin
    den_nxt = (DW'(timer) + DW'(1)) * DW'(atmnb_pkg::A4_HZ);
    if (op) begin
      num_nxt = NW'(atmnb_pkg::CLOCK_HZ) << (atmnb_pkg::MANT_BITS - atmnb_pkg::TRI_DIV_LOG2);
    end else begin
      num_nxt = NW'(atmnb_pkg::CLOCK_HZ) << (atmnb_pkg::MANT_BITS - atmnb_pkg::PULSE_DIV_LOG2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den_nxt;
      rem_r[0] <= DW'(num_nxt[NW-1:QW]);
      nq_r[0]  <= num_nxt[QW-1:0];
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem_r[k-1], nq_r[k-1][QW-1]};
    assign diff  = trial - {1'b0, den_r[k-1]};
    assign ge    = (trial >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_r[k-1];
        rem_r[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nq_r[k]  <= {nq_r[k-1][QW-2:0], ge};
      end
    end
  end

  assign out_valid = v_r[QW];
  assign quo       = nq_r[QW];

endmodule
`default_nettype wire

### hdl/atmnb_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atmnb_norm
// Pipelined leading-zero search that normalizes the ratio to a Q30
// mantissa in [1,2) and the matching integer part of log2.
// ----------------------------------------------------------------------------
module atmnb_norm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  atmnb_pkg::quo_t   quo,
  output logic              out_valid,
  output atmnb_pkg::mant_t  mant,
  output atmnb_pkg::exp_t   expo
);

  localparam int QW = atmnb_pkg::QUO_W;
  localparam int LW = atmnb_pkg::LZC_W;
  localparam int EW = atmnb_pkg::EXP_W;

  logic          v_in [LW];
  logic [QW-1:0] w_in [LW];
  logic [LW-1:0] z_in [LW];
  logic          v_r  [LW];
  logic [QW-1:0] w_r  [LW];
  logic [LW-1:0] z_r  [LW];

  assign v_in[0] = in_valid;
  assign w_in[0] = quo;
  assign z_in[0] = '0;

  for (genvar j = 0; j < LW; j++) begin : g_step
    localparam int SH = 1 << (LW - 1 - j);
    logic zero;

    if (j > 0) begin : g_link
      assign v_in[j] = v_r[j-1];
      assign w_in[j] = w_r[j-1];
      assign z_in[j] = z_r[j-1];
    end

    assign zero = (w_in[j][QW-1 -: SH] == '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w_r[j] <= zero ? (w_in[j] << SH) : w_in[j];
        z_r[j] <= z_in[j] | (zero ? LW'(SH) : LW'(0));
      end
    end
  end

  assign out_valid = v_r[LW-1];
  assign mant      = w_r[LW-1][QW-1 -: atmnb_pkg::MANT_W];
  assign expo      = $signed(EW'(atmnb_pkg::NORM_TOP) - EW'(z_r[LW-1]));

endmodule
`default_nettype wire

### hdl/atmnb_log.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atmnb_log
// Fractional log2 by repeated squaring of the Q30 mantissa, one fraction
// bit per pipeline stage.
// ----------------------------------------------------------------------------
module atmnb_log #(
  parameter int LOG_FRAC_BITS = atmnb_pkg::LOG_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  atmnb_pkg::mant_t         mant,
  input  atmnb_pkg::exp_t          expo,
  output logic                     out_valid,
  output logic [LOG_FRAC_BITS-1:0] frac,
  output atmnb_pkg::exp_t          frac_expo
);

  localparam int F  = LOG_FRAC_BITS;
  localparam int MW = atmnb_pkg::MANT_W;
  localparam int MB = atmnb_pkg::MANT_BITS;

  logic             v_in [F];
  atmnb_pkg::mant_t m_in [F];
  logic [F-1:0]     f_in [F];
  atmnb_pkg::exp_t  e_in [F];
  logic             v_r  [F];
  atmnb_pkg::mant_t m_r  [F];
  logic [F-1:0]     f_r  [F];
  atmnb_pkg::exp_t  e_r  [F];

  assign v_in[0] = in_valid;
  assign m_in[0] = mant;
  assign f_in[0] = '0;
  assign e_in[0] = expo;

  for (genvar j = 0; j < F; j++) begin : g_step
    logic [2*MW-1:0] sq;
    logic [MW:0]     sq_q;

    if (j > 0) begin : g_link
      assign v_in[j] = v_r[j-1];
      assign m_in[j] = m_r[j-1];
      assign f_in[j] = f_r[j-1];
      assign e_in[j] = e_r[j-1];
    end

    assign sq   = m_in[j] * m_in[j];
    assign sq_q = sq[MB +: MW+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in[j];
      end
    end

    // A square of two or more yields a one bit and is halved.
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[j] <= sq_q[MW] ? sq_q[MW:1] : sq_q[MW-1:0];
        f_r[j] <= {f_in[j][F-2:0], sq_q[MW]};
        e_r[j] <= e_in[j];
      end
    end
  end

  assign out_valid = v_r[F-1];
  assign frac      = f_r[F-1];
  assign frac_expo = e_r[F-1];

endmodule
`default_nettype wire

### hdl/atmnb_pitch.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atmnb_pitch
// Scales log2 to 1/4096 semitone around note 69, then splits the pitch into
// the nearest note and the remaining pitch bend.
// ----------------------------------------------------------------------------
module atmnb_pitch #(
  parameter int LOG_FRAC_BITS = atmnb_pkg::LOG_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [LOG_FRAC_BITS-1:0] frac,
  input  atmnb_pkg::exp_t          expo,
  output logic                     out_valid,
  output atmnb_pkg::res_t          res
);

  localparam int F  = LOG_FRAC_BITS;
  localparam int FW = atmnb_pkg::FP_W;
  localparam int PW = atmnb_pkg::PITCH_W;
  localparam int SB = atmnb_pkg::SEMI_BITS;
  localparam int BW = atmnb_pkg::BEND_W;
  localparam logic signed [PW-1:0] SEMI_S = PW'(atmnb_pkg::SEMI_Q);

  logic [F+FW-1:0]       prod;
  logic signed [PW-1:0]  e_ext;
  logic [FW-1:0]         fp_r;
  logic signed [PW-1:0]  eq_r;
  logic                  va_r;
  logic signed [PW-1:0]  p;
  logic [PW-1:0]         p2;
  atmnb_pkg::res_t       res_nxt;
  atmnb_pkg::res_t       res_r;
  logic                  vb_r;

  // The integer part of log2 contributes whole multiples of the scale, so
  // only the fraction needs rounding.
  assign prod  = (F+FW)'(frac) * (F+FW)'(atmnb_pkg::SEMI_Q) + ((F+FW)'(1) << (F - 1));
  assign e_ext = PW'(expo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fp_r <= prod[F +: FW];
      eq_r <= e_ext * SEMI_S;
    end
  end

  always_comb begin
    p = eq_r + PW'(atmnb_pkg::NOTE_BASE) + $signed(PW'(fp_r));
    if (p < 0) begin
      p = '0;
    end
    p2 = PW'(p) + PW'(atmnb_pkg::HALF_SEMI);
    res_nxt.note = p2[SB +: atmnb_pkg::NOTE_W];
    res_nxt.bend = BW'(atmnb_pkg::BEND_CENTRE - atmnb_pkg::HALF_SEMI) + BW'(p2[SB-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = vb_r;
  assign res       = res_r;

endmodule
`default_nettype wire

### hdl/apu_timer_to_midi_note_bend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apu_timer_to_midi_note_bend
// Converts a tone channel timer value into the nearest MIDI note and a
// 14-bit pitch bend.
// ----------------------------------------------------------------------------
// The block accepts one timer value per clock and returns one note/bend
// result for each, in order. A result passes one input stage, 38 divider
// stages that each resolve one quotient bit of the frequency ratio, 6
// normalization stages, one squaring stage per log2 fraction bit, two pitch
// stages and the output buffer before it reaches the output. The output
// buffer holds two results, so the input side keeps taking values while a
// result waits, and stops only when both entries are occupied.
module apu_timer_to_midi_note_bend #(
  parameter int LOG_FRAC_BITS = atmnb_pkg::LOG_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  atmnb_in_if.sink           in_ch,
  atmnb_out_if.source        out_ch
);

  logic             en;
  logic             div_valid;
  atmnb_pkg::quo_t  div_quo;
  logic             norm_valid;
  atmnb_pkg::mant_t norm_mant;
  atmnb_pkg::exp_t  norm_expo;
  logic             log_valid;
  logic [LOG_FRAC_BITS-1:0] log_frac;
  atmnb_pkg::exp_t  log_expo;
  logic             pit_valid;
  atmnb_pkg::res_t  pit_res;

  logic [1:0]       cnt_r;
  atmnb_pkg::res_t  ent0_r;
  atmnb_pkg::res_t  ent1_r;
  logic             push;
  logic             pop;

  assign en          = (cnt_r != 2'd2);
  assign in_ch.ready = en;

  atmnb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .timer     (in_ch.timer),
    .op        (in_ch.op),
    .out_valid (div_valid),
    .quo       (div_quo)
  );

  atmnb_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_valid),
    .quo       (div_quo),
    .out_valid (norm_valid),
    .mant      (norm_mant),
    .expo      (norm_expo)
  );

  atmnb_log #(
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_log (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (norm_valid),
    .mant      (norm_mant),
    .expo      (norm_expo),
    .out_valid (log_valid),
    .frac      (log_frac),
    .frac_expo (log_expo)
  );

  atmnb_pitch #(
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (log_valid),
    .frac      (log_frac),
    .expo      (log_expo),
    .out_valid (pit_valid),
    .res       (pit_res)
  );

  assign push = en && pit_valid;
  assign pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (push && !pop) begin
      cnt_r <= cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // A transfer in while the head leaves always lands in the head entry,
  // since the buffer then holds exactly one result.
  always_ff @(posedge clk) begin
    if (push && pop) begin
      ent0_r <= pit_res;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        ent0_r <= pit_res;
      end else begin
        ent1_r <= pit_res;
      end
    end else if (pop) begin
      ent0_r <= ent1_r;
    end
  end

  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.note  = ent0_r.note;
  assign out_ch.bend  = ent0_r.bend;

endmodule
`default_nettype wire
